>>> src/mfre_pkg.sv
// ---------------------------------------------------------------------------
// mfre_pkg
// shared constants, command codes and controller/datapath interface types
// for the monochrome frame store raster engine
// ---------------------------------------------------------------------------
package mfre_pkg;

    // default panel geometry
    localparam int MFRE_COLUMNS = 128;
    localparam int MFRE_PAGES   = 8;

    // slope fixed-point scale and its reciprocal for constant division
    localparam int SLOPE_SCALE  = 10;
    localparam int RECIP_MUL    = 205;
    localparam int RECIP_SHIFT  = 11;

    // command codes
    localparam logic [2:0] OP_SET_PIXEL = 3'd0;
    localparam logic [2:0] OP_CLR_PIXEL = 3'd1;
    localparam logic [2:0] OP_LINE      = 3'd2;
    localparam logic [2:0] OP_CIRCLE    = 3'd3;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd4;
    localparam logic [2:0] OP_READ_BYTE = 3'd5;

    // pixel source selection
    typedef logic [1:0] t_pix_src;
    localparam t_pix_src PIX_POINT  = 2'd0;
    localparam t_pix_src PIX_LINE   = 2'd1;
    localparam t_pix_src PIX_CIRCLE = 2'd2;

    typedef struct packed {
        logic     load;
        logic     reject;
        logic     line_init;
        logic     line_step;
        logic     div_init;
        logic     div_step;
        logic     prep_kq;
        logic     prep_kr;
        logic     circ_init;
        logic     circ_step;
        logic     pt_clr;
        logic     pt_next;
        logic     pix_latch;
        logic     pix_write;
        logic     clr_init;
        logic     clr_step;
        logic     rdb_issue;
        logic     rdb_capture;
        t_pix_src pix_src;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       line_reject;
        logic       line_diag;
        logic       radius_zero;
        logic       clr_last;
        logic       div_last;
        logic       line_end;
        logic       circ_go;
        logic       pt_last;
    } t_dp_sts;

endpackage

>>> src/mfre_datapath.sv
// ---------------------------------------------------------------------------
// mfre_datapath
// frame store memory, pixel read-modify-write, line and circle walkers,
// slope divider and clearing sweep
// ---------------------------------------------------------------------------
module mfre_datapath #(
    parameter int PANEL_COLUMNS = mfre_pkg::MFRE_COLUMNS,
    parameter int PANEL_PAGES   = mfre_pkg::MFRE_PAGES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [2:0]        i_op,
    input  logic [7:0]        i_x_a,
    input  logic [7:0]        i_y_a,
    input  logic [7:0]        i_x_b,
    input  logic [7:0]        i_y_b,
    input  logic [7:0]        i_radius,
    input  mfre_pkg::t_dp_cmd i_cmd,
    output mfre_pkg::t_dp_sts o_sts,
    output logic [7:0]        o_read_byte,
    output logic              o_accepted
);

    localparam int DEPTH = PANEL_COLUMNS * PANEL_PAGES;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_mem_q;

    // latched command
    logic [2:0] r_op;
    logic [7:0] r_xa, r_ya, r_xb, r_yb, r_rad;
    logic       r_ok;
    logic [7:0] r_rd;

    // clearing sweep
    logic [AW-1:0] r_caddr;

    // line walker
    logic [7:0] r_px, r_py, r_cnt, r_len;
    logic [3:0] r_rem;
    logic       r_vert, r_horiz;
    logic [11:0] r_dnum;
    logic [7:0]  r_drem;
    logic [3:0]  r_dcnt;
    logic [7:0]  r_kq;
    logic [3:0]  r_kr;

    // circle walker
    logic [7:0]  r_ca, r_cb;
    logic [15:0] r_aa, r_bb, r_rr;
    logic [2:0]  r_pt;

    // pixel request
    logic [AW-1:0] r_paddr;
    logic [7:0]    r_pmask;
    logic          r_pvalid;
    logic          r_pon;

    logic [7:0]    dx, dy;
    logic [8:0]    div_sh;
    logic          div_ge;
    logic [15:0]   k_prod;
    logic [7:0]    kq_x10;
    logic [4:0]    rem_sum;
    logic          rem_wrap;
    logic [15:0]   rad_sq;
    logic [16:0]   aa_n;
    logic [17:0]   circ_sum;
    logic [7:0]    pix_x, pix_y;
    logic [4:0]    pix_page;
    logic          pix_ok;
    logic [AW-1:0] pix_addr, rb_addr, rd_addr;
    logic          rb_ok;

    assign dx      = r_xb - r_xa;
    assign dy      = r_yb - r_ya;
    assign div_sh  = {r_drem, r_dnum[11]};
    assign div_ge  = div_sh >= {1'b0, dx};
    assign k_prod  = 16'(r_dnum[7:0]) * 16'(mfre_pkg::RECIP_MUL);
    assign kq_x10  = {r_kq[4:0], 3'b000} + {r_kq[6:0], 1'b0};
    assign rem_sum = 5'(r_rem) + 5'(r_kr);
    assign rem_wrap = rem_sum >= 5'(mfre_pkg::SLOPE_SCALE);
    assign rad_sq  = 16'(i_radius) * 16'(i_radius);
    assign aa_n    = 17'(r_aa) + 17'({r_ca, 1'b1});
    assign circ_sum = 18'(aa_n) + 18'(r_bb);

    // pixel coordinate selection, eight-way symmetry for circles
    always_comb begin
        pix_x = r_xa;
        pix_y = r_ya;
        unique case (i_cmd.pix_src)
            mfre_pkg::PIX_LINE: begin
                pix_x = r_px;
                pix_y = r_py;
            end
            mfre_pkg::PIX_CIRCLE: begin
                unique case (r_pt)
                    3'd0: begin pix_x = r_xa + r_ca; pix_y = r_ya - r_cb; end
                    3'd1: begin pix_x = r_xa - r_ca; pix_y = r_ya - r_cb; end
                    3'd2: begin pix_x = r_xa - r_ca; pix_y = r_ya + r_cb; end
                    3'd3: begin pix_x = r_xa + r_ca; pix_y = r_ya + r_cb; end
                    3'd4: begin pix_x = r_xa + r_cb; pix_y = r_ya + r_ca; end
                    3'd5: begin pix_x = r_xa + r_cb; pix_y = r_ya - r_ca; end
                    3'd6: begin pix_x = r_xa - r_cb; pix_y = r_ya - r_ca; end
                    3'd7: begin pix_x = r_xa - r_cb; pix_y = r_ya + r_ca; end
                endcase
            end
            default: begin
                pix_x = r_xa;
                pix_y = r_ya;
            end
        endcase
    end

    assign pix_page = pix_y[7:3];
    assign pix_ok   = ({1'b0, pix_x} < 9'(PANEL_COLUMNS))
                    && ({1'b0, pix_page} < 6'(PANEL_PAGES));
    assign pix_addr = AW'(AW'(pix_x) * AW'(PANEL_PAGES) + AW'(pix_page));
    assign rb_ok    = ({1'b0, r_xa} < 9'(PANEL_COLUMNS))
                    && ({1'b0, r_ya} < 9'(PANEL_PAGES));
    assign rb_addr  = AW'(AW'(r_xa) * AW'(PANEL_PAGES) + AW'(r_ya));
    assign rd_addr  = i_cmd.rdb_issue ? rb_addr : pix_addr;

    // frame store
    always_ff @(posedge i_clk) begin
        r_mem_q <= mem[rd_addr];
        if (i_cmd.clr_step) begin
            mem[r_caddr] <= 8'h00;
        end else if (i_cmd.pix_write && r_pvalid) begin
            mem[r_paddr] <= r_pon ? (r_mem_q | r_pmask) : (r_mem_q & ~r_pmask);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caddr <= '0;
            r_ok    <= 1'b0;
        end else begin
            if (i_cmd.clr_init) begin
                r_caddr <= '0;
            end else if (i_cmd.clr_step) begin
                r_caddr <= r_caddr + 1'b1;
            end
            if (i_cmd.load) begin
                r_ok <= 1'b1;
            end else if (i_cmd.reject) begin
                r_ok <= 1'b0;
            end
        end
    end

    // payload and walker registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_xa  <= i_x_a;
            r_ya  <= i_y_a;
            r_xb  <= i_x_b;
            r_yb  <= i_y_b;
            r_rad <= i_radius;
            r_rd  <= 8'h00;
            r_rr  <= rad_sq;
            r_bb  <= rad_sq;
        end
        if (i_cmd.line_init) begin
            r_px    <= r_xa;
            r_py    <= r_ya;
            r_cnt   <= 8'h00;
            r_rem   <= 4'h0;
            r_vert  <= r_xa == r_xb;
            r_horiz <= r_ya == r_yb;
            r_len   <= (r_xa == r_xb) ? dy : dx;
        end else if (i_cmd.line_step) begin
            r_cnt <= r_cnt + 8'd1;
            if (r_vert) begin
                r_py <= r_py + 8'd1;
            end else if (r_horiz) begin
                r_px <= r_px + 8'd1;
            end else begin
                r_px  <= r_px + 8'd1;
                r_py  <= r_py + r_kq + 8'(rem_wrap);
                r_rem <= rem_wrap ? 4'(rem_sum - 5'(mfre_pkg::SLOPE_SCALE)) : rem_sum[3:0];
            end
        end
        if (i_cmd.div_init) begin
            r_dnum <= {dy, 3'b000} + {3'b000, dy, 1'b0};
            r_drem <= 8'h00;
            r_dcnt <= 4'd0;
        end else if (i_cmd.div_step) begin
            r_drem <= div_ge ? 8'(div_sh - {1'b0, dx}) : div_sh[7:0];
            r_dnum <= {r_dnum[10:0], div_ge};
            r_dcnt <= r_dcnt + 4'd1;
        end
        if (i_cmd.prep_kq) begin
            r_kq <= 8'(k_prod >> mfre_pkg::RECIP_SHIFT);
        end
        if (i_cmd.prep_kr) begin
            r_kr <= 4'(r_dnum[7:0] - kq_x10);
        end
        if (i_cmd.circ_init) begin
            r_ca <= 8'h00;
            r_cb <= r_rad;
            r_aa <= 16'h0000;
        end else if (i_cmd.circ_step) begin
            if (circ_sum > 18'(r_rr)) begin
                r_cb <= r_cb - 8'd1;
                r_bb <= r_bb - 16'({r_cb, 1'b0}) + 16'd1;
            end else begin
                r_ca <= r_ca + 8'd1;
                r_aa <= aa_n[15:0];
            end
        end
        if (i_cmd.pt_clr) begin
            r_pt <= 3'd0;
        end else if (i_cmd.pt_next) begin
            r_pt <= r_pt + 3'd1;
        end
        if (i_cmd.pix_latch) begin
            r_paddr  <= pix_addr;
            r_pmask  <= 8'h01 << pix_y[2:0];
            r_pvalid <= pix_ok;
            r_pon    <= (r_op != mfre_pkg::OP_CLR_PIXEL);
        end else if (i_cmd.rdb_issue) begin
            r_pvalid <= rb_ok;
        end
        if (i_cmd.rdb_capture) begin
            r_rd <= r_pvalid ? r_mem_q : 8'h00;
        end
    end

    always_comb begin
        o_sts.op          = r_op;
        o_sts.line_reject = ({1'b0, r_xb} > 9'(PANEL_COLUMNS))
                          || ({1'b0, r_yb} > 9'(8 * PANEL_PAGES))
                          || (r_xa > r_xb) || (r_ya > r_yb);
        o_sts.line_diag   = (r_xa != r_xb) && (r_ya != r_yb);
        o_sts.radius_zero = r_rad == 8'h00;
        o_sts.clr_last    = r_caddr == AW'(DEPTH - 1);
        o_sts.div_last    = r_dcnt == 4'd11;
        o_sts.line_end    = r_cnt == r_len;
        o_sts.circ_go     = {r_bb, 1'b0} >= {1'b0, r_rr};
        o_sts.pt_last     = r_pt == 3'd7;
    end

    assign o_read_byte = r_rd;
    assign o_accepted  = r_ok;

endmodule

>>> src/mfre_controller.sv
// ---------------------------------------------------------------------------
// mfre_controller
// command sequencer: decodes a transaction and steps the datapath through
// clearing, division, line and circle walks and pixel read-modify-write
// ---------------------------------------------------------------------------
module mfre_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  mfre_pkg::t_dp_sts i_sts,
    output mfre_pkg::t_dp_cmd o_cmd,
    output logic              busy,
    output logic              o_done
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_CLR    = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_PREP1  = 4'd5;
    localparam logic [3:0] S_PREP2  = 4'd6;
    localparam logic [3:0] S_LINE   = 4'd7;
    localparam logic [3:0] S_CTEST  = 4'd8;
    localparam logic [3:0] S_RD     = 4'd9;
    localparam logic [3:0] S_WR     = 4'd10;
    localparam logic [3:0] S_CUPD   = 4'd11;
    localparam logic [3:0] S_RDB    = 4'd12;
    localparam logic [3:0] S_RDW    = 4'd13;
    localparam logic [3:0] S_DONE   = 4'd14;

    logic [3:0]         r_state, n_state;
    mfre_pkg::t_pix_src r_mode, n_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_mode  <= mfre_pkg::PIX_POINT;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        o_cmd         = '0;
        o_cmd.pix_src = r_mode;
        unique case (r_state)
            S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.op)
                    mfre_pkg::OP_SET_PIXEL, mfre_pkg::OP_CLR_PIXEL: begin
                        n_mode  = mfre_pkg::PIX_POINT;
                        n_state = S_RD;
                    end
                    mfre_pkg::OP_LINE: begin
                        n_mode = mfre_pkg::PIX_LINE;
                        if (i_sts.line_reject) begin
                            o_cmd.reject = 1'b1;
                            n_state      = S_DONE;
                        end else if (i_sts.line_diag) begin
                            o_cmd.line_init = 1'b1;
                            o_cmd.div_init  = 1'b1;
                            n_state         = S_DIV;
                        end else begin
                            o_cmd.line_init = 1'b1;
                            n_state         = S_LINE;
                        end
                    end
                    mfre_pkg::OP_CIRCLE: begin
                        if (i_sts.radius_zero) begin
                            n_mode  = mfre_pkg::PIX_POINT;
                            n_state = S_RD;
                        end else begin
                            n_mode          = mfre_pkg::PIX_CIRCLE;
                            o_cmd.circ_init = 1'b1;
                            n_state         = S_CTEST;
                        end
                    end
                    mfre_pkg::OP_CLEAR_ALL: begin
                        o_cmd.clr_init = 1'b1;
                        n_state        = S_CLR;
                    end
                    mfre_pkg::OP_READ_BYTE: n_state = S_RDB;
                    default: begin
                        o_cmd.reject = 1'b1;
                        n_state      = S_DONE;
                    end
                endcase
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) n_state = S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) n_state = S_PREP1;
            end
            S_PREP1: begin
                o_cmd.prep_kq = 1'b1;
                n_state       = S_PREP2;
            end
            S_PREP2: begin
                o_cmd.prep_kr = 1'b1;
                n_state       = S_LINE;
            end
            S_LINE: begin
                n_state = i_sts.line_end ? S_DONE : S_RD;
            end
            S_CTEST: begin
                if (i_sts.circ_go) begin
                    o_cmd.pt_clr = 1'b1;
                    n_state      = S_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                o_cmd.pix_latch = 1'b1;
                n_state         = S_WR;
            end
            S_WR: begin
                o_cmd.pix_write = 1'b1;
                unique case (r_mode)
                    mfre_pkg::PIX_LINE: begin
                        o_cmd.line_step = 1'b1;
                        n_state         = S_LINE;
                    end
                    mfre_pkg::PIX_CIRCLE: begin
                        if (i_sts.pt_last) begin
                            n_state = S_CUPD;
                        end else begin
                            o_cmd.pt_next = 1'b1;
                            n_state       = S_RD;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_CUPD: begin
                o_cmd.circ_step = 1'b1;
                n_state         = S_CTEST;
            end
            S_RDB: begin
                o_cmd.rdb_issue = 1'b1;
                n_state         = S_RDW;
            end
            S_RDW: begin
                o_cmd.rdb_capture = 1'b1;
                n_state           = S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign busy   = r_state != S_IDLE;
    assign o_done = r_state == S_DONE;

    // the result cycle always hands back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("result strobe not followed by idle");

    // an accepted transaction is decoded next cycle
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_DECODE))
        else $error("accepted transaction not decoded");

    // clearing sweep and pixel write never share the write port
    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.clr_step && o_cmd.pix_write))
        else $error("two writers on frame store");

    // no result strobe while the store is still being cleared after reset
    a_no_done_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_done)
        else $error("result during reset clearing");

endmodule

>>> src/mono_framebuffer_raster_engine.sv
// ---------------------------------------------------------------------------
// mono_framebuffer_raster_engine
// one-bit page-format frame store with pixel, line, circle, clear and read
// commands
// ---------------------------------------------------------------------------
// a command is taken when start is high and busy is low; busy stays high
// until the single result has been shown. the result (o_read_byte,
// o_accepted) is valid for exactly one cycle while o_done is high and must be
// captured then, as there is no way to hold it. after reset the block runs a
// clearing pass over all PANEL_COLUMNS*PANEL_PAGES bytes of the frame store
// (1024 by default) with busy high. every pixel is a read-modify-write on the
// single frame store port: the pixel's address and mask are latched with the
// read of its byte, then the modified byte is written back. clear all sweeps
// every byte of the store to zero; a diagonal line first runs a slope division
// before its walk; a circle plots eight points, then an update and a test, for
// every step of its a/b walk.
// ---------------------------------------------------------------------------
module mono_framebuffer_raster_engine #(
    parameter int PANEL_COLUMNS = mfre_pkg::MFRE_COLUMNS,
    parameter int PANEL_PAGES   = mfre_pkg::MFRE_PAGES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] i_op,
    input  logic [7:0] i_x_a,
    input  logic [7:0] i_y_a,
    input  logic [7:0] i_x_b,
    input  logic [7:0] i_y_b,
    input  logic [7:0] i_radius,
    output logic       o_done,
    output logic [7:0] o_read_byte,
    output logic       o_accepted
);

    // command and status between sequencer and datapath
    mfre_pkg::t_dp_cmd cmd;
    mfre_pkg::t_dp_sts sts;

    mfre_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    // frame store, walkers and result registers
    mfre_datapath #(
        .PANEL_COLUMNS (PANEL_COLUMNS),
        .PANEL_PAGES   (PANEL_PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (i_op),
        .i_x_a       (i_x_a),
        .i_y_a       (i_y_a),
        .i_x_b       (i_x_b),
        .i_y_b       (i_y_b),
        .i_radius    (i_radius),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_read_byte (o_read_byte),
        .o_accepted  (o_accepted)
    );

endmodule
